// ===== rtl/core/rlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlm_pkg
// Types, codes and sizes shared by the recursive lock manager.
// ----------------------------------------------------------------------------
package rlm_pkg;

    localparam int LOCK_ENTRIES = 16;
    localparam int WAITER_DEPTH = 8;
    localparam int EIDX_W = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int WPOS_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WAITER_DEPTH + 1);
    localparam int SLOTS  = LOCK_ENTRIES * WAITER_DEPTH;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] MAX_COUNT  = 32'h7fff_ffff;
    localparam logic [31:0] FREE_COUNT = 32'hffff_ffff;
    localparam logic [30:0] MAX_DEPTH  = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_ENTER    = 3'd1,
        OP_COMPLETE = 3'd2,
        OP_LEAVE    = 3'd3,
        OP_STOP     = 3'd4
    } op_t;

    typedef enum logic [4:0] {
        ST_ACQUIRED      = 5'd0,
        ST_RECURSED      = 5'd1,
        ST_QUEUED        = 5'd2,
        ST_COMPLETED     = 5'd3,
        ST_REL_HELD      = 5'd4,
        ST_REL_FREE      = 5'd5,
        ST_REL_HANDOFF   = 5'd6,
        ST_INITIALIZED   = 5'd7,
        ST_STOPPED       = 5'd8,
        ST_MISALIGNED    = 5'd9,
        ST_NULL_THREAD   = 5'd10,
        ST_IS_STOPPED    = 5'd11,
        ST_INIT_ACTIVE   = 5'd12,
        ST_OVERFLOW      = 5'd13,
        ST_FIFO_FULL     = 5'd14,
        ST_NOT_OWNER     = 5'd15,
        ST_NOT_SELECTED  = 5'd16,
        ST_UNKNOWN       = 5'd17
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] lock_address;
        logic [31:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [4:0]  status;
        logic        woken_valid;
        logic [31:0] woken_thread;
    } rsp_t;

    // Per-entry lock record
    typedef struct packed {
        logic [29:0]       tag;
        logic [31:0]       count;
        logic [30:0]       depth;
        logic [31:0]       owner;
        logic              selected;
        logic [WPOS_W-1:0] head;
        logic [WCNT_W-1:0] fill;
    } entry_t;

    // Table lookup result passed to the operation logic
    typedef struct packed {
        logic              hit;
        logic [EIDX_W-1:0] hit_idx;
        logic              has_free;
        logic [EIDX_W-1:0] free_idx;
    } lookup_t;

    // Update command from the operation logic to the table
    typedef struct packed {
        logic              wr_entry;
        logic              set_valid;
        logic [EIDX_W-1:0] idx;
        entry_t            data;
        logic              wr_waiter;
        logic              set_head;
        logic              adv_head;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       waiter;
        logic              set_stop;
    } update_t;

endpackage

// ===== rtl/core/rlm_table.sv =====
// ----------------------------------------------------------------------------
// rlm_table
// Lock table: entry registers, valid bits, tag match, head waiter registers
// and waiter memory with a registered read for the next head.
// ----------------------------------------------------------------------------
module rlm_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [29:0]           tag,
    input  logic [rlm_pkg::SLOT_W-1:0] rd_slot,
    input  rlm_pkg::update_t      upd,
    output rlm_pkg::lookup_t      lkp,
    output rlm_pkg::entry_t       hit_entry,
    output logic [31:0]           head_waiter,
    output logic                  stopping
);
    import rlm_pkg::*;

    logic [LOCK_ENTRIES-1:0] valid_reg;
    entry_t                  entry_reg [LOCK_ENTRIES];
    logic [31:0]             head_reg [LOCK_ENTRIES];
    logic [31:0]             waiter_mem [SLOTS];
    logic                    stop_reg;
    logic                    fix_pend_reg;
    logic [EIDX_W-1:0]       fix_idx_reg;
    logic [31:0]             fix_data_reg;

    // Match tag and find first free entry
    always_comb
    begin
        lkp = '0;
        for (int i = LOCK_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && entry_reg[i].tag == tag)
            begin
                lkp.hit     = 1'b1;
                lkp.hit_idx = EIDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                lkp.has_free = 1'b1;
                lkp.free_idx = EIDX_W'(i);
            end
        end
    end

    assign hit_entry = entry_reg[lkp.hit_idx];
    assign stopping  = stop_reg;

    // Take the freshly read head while it is still on its way to the register
    assign head_waiter = (fix_pend_reg && fix_idx_reg == lkp.hit_idx) ? fix_data_reg
                                                                      : head_reg[lkp.hit_idx];

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            stop_reg     <= 1'b0;
            fix_pend_reg <= 1'b0;
        end
        else
        begin
            if (upd.wr_entry && upd.set_valid)
                valid_reg[upd.idx] <= 1'b1;
            if (upd.set_stop)
                stop_reg <= 1'b1;
            fix_pend_reg <= upd.adv_head;
        end
    end

    // Write entry payload
    always_ff @(posedge clk)
    begin
        if (upd.wr_entry)
            entry_reg[upd.idx] <= upd.data;
    end

    // Load head waiter: a queue into an empty list wins over a pending head read
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LOCK_ENTRIES; i++)
        begin
            if (upd.wr_waiter && upd.set_head && upd.idx == EIDX_W'(i))
                head_reg[i] <= upd.waiter;
            else if (fix_pend_reg && fix_idx_reg == EIDX_W'(i))
                head_reg[i] <= fix_data_reg;
        end
    end

    // Write waiter memory, read the next head when the head advances
    always_ff @(posedge clk)
    begin
        if (upd.wr_waiter)
            waiter_mem[upd.slot] <= upd.waiter;
        if (upd.adv_head)
        begin
            fix_data_reg <= waiter_mem[rd_slot];
            fix_idx_reg  <= upd.idx;
        end
    end

endmodule

// ===== rtl/core/rlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlm_ctrl
// Operation logic: checks, entry update and result for one transfer.
// ----------------------------------------------------------------------------
module rlm_ctrl (
    input  rlm_pkg::req_t              req,
    input  logic                       go,
    input  rlm_pkg::lookup_t           lkp,
    input  rlm_pkg::entry_t            ent,
    input  logic [31:0]                head_waiter,
    input  logic                       stopping,
    output logic [rlm_pkg::SLOT_W-1:0] rd_slot,
    output rlm_pkg::update_t           upd,
    output rlm_pkg::rsp_t              rsp
);
    import rlm_pkg::*;

    logic [29:0]       tag;
    logic [WPOS_W-1:0] tail_pos;
    logic [WPOS_W-1:0] head_inc;

    assign tag = req.lock_address[31:2];

    // Slot addresses, wrapping at the waiter depth
    always_comb
    begin
        tail_pos = WPOS_W'((32'(ent.head) + 32'(ent.fill)) % WAITER_DEPTH);
        head_inc = WPOS_W'((32'(ent.head) + 32'd1) % WAITER_DEPTH);
    end

    // Slot of the waiter that becomes head once the current head completes
    assign rd_slot = SLOT_W'(32'(lkp.hit_idx) * WAITER_DEPTH + 32'(head_inc));

    // Decode operation
    always_comb
    begin
        upd        = '0;
        upd.idx    = lkp.hit_idx;
        upd.data   = ent;
        upd.waiter = req.thread_id;
        upd.slot   = SLOT_W'(32'(lkp.hit_idx) * WAITER_DEPTH + 32'(tail_pos));
        rsp        = '0;
        rsp.status = ST_UNKNOWN;
        priority if (req.opcode > OP_STOP)
            rsp.status = ST_UNKNOWN;
        else if (req.opcode == OP_STOP)
        begin
            upd.set_stop = go;
            rsp.status   = ST_STOPPED;
        end
        else if (stopping)
            rsp.status = ST_IS_STOPPED;
        else if (req.lock_address[1:0] != 2'b00)
            rsp.status = ST_MISALIGNED;
        else if (req.opcode != OP_INIT && req.thread_id == '0)
            rsp.status = ST_NULL_THREAD;
        else if (req.opcode == OP_INIT)
        begin
            if (lkp.hit && (ent.owner != '0 || ent.depth != '0 || ent.fill != '0
                            || ent.selected))
                rsp.status = ST_INIT_ACTIVE;
            else if (!lkp.hit && !lkp.has_free)
                rsp.status = ST_UNKNOWN;
            else
            begin
                upd.wr_entry  = go;
                upd.set_valid = 1'b1;
                upd.idx       = lkp.hit ? lkp.hit_idx : lkp.free_idx;
                upd.data      = '{tag: tag, count: FREE_COUNT, depth: '0, owner: '0,
                                  selected: 1'b0, head: '0, fill: '0};
                rsp.status    = ST_INITIALIZED;
            end
        end
        else if (!lkp.hit)
            rsp.status = ST_UNKNOWN;
        else if (req.opcode == OP_ENTER)
        begin
            if (ent.owner == req.thread_id)
            begin
                if (ent.depth == MAX_DEPTH || ent.count == MAX_COUNT)
                    rsp.status = ST_OVERFLOW;
                else
                begin
                    upd.wr_entry   = go;
                    upd.data.count = ent.count + 32'd1;
                    upd.data.depth = ent.depth + 31'd1;
                    rsp.status     = ST_RECURSED;
                end
            end
            else if (ent.owner == '0 && ent.count == FREE_COUNT)
            begin
                upd.wr_entry   = go;
                upd.data.count = '0;
                upd.data.depth = 31'd1;
                upd.data.owner = req.thread_id;
                rsp.status     = ST_ACQUIRED;
            end
            else if (ent.count == MAX_COUNT)
                rsp.status = ST_OVERFLOW;
            else if (32'(ent.fill) >= WAITER_DEPTH)
                rsp.status = ST_FIFO_FULL;
            else
            begin
                upd.wr_entry   = go;
                upd.wr_waiter  = go;
                upd.set_head   = (ent.fill == '0);
                upd.data.fill  = ent.fill + WCNT_W'(1);
                upd.data.count = ent.count + 32'd1;
                rsp.status     = ST_QUEUED;
            end
        end
        else if (req.opcode == OP_COMPLETE)
        begin
            if (!ent.selected || ent.fill == '0 || head_waiter != req.thread_id
                || ent.owner != '0 || ent.depth != '0)
                rsp.status = ST_NOT_SELECTED;
            else
            begin
                upd.wr_entry      = go;
                upd.adv_head      = go;
                upd.data.depth    = 31'd1;
                upd.data.owner    = req.thread_id;
                upd.data.selected = 1'b0;
                upd.data.head     = head_inc;
                upd.data.fill     = ent.fill - WCNT_W'(1);
                rsp.status        = ST_COMPLETED;
            end
        end
        else
        begin
            if (ent.owner != req.thread_id || ent.depth == '0)
                rsp.status = ST_NOT_OWNER;
            else if (ent.depth > 31'd1)
            begin
                upd.wr_entry   = go;
                upd.data.count = ent.count - 32'd1;
                upd.data.depth = ent.depth - 31'd1;
                rsp.status     = ST_REL_HELD;
            end
            else if (ent.fill != '0 && ent.selected)
                rsp.status = ST_NOT_SELECTED;
            else
            begin
                upd.wr_entry   = go;
                upd.data.depth = '0;
                upd.data.owner = '0;
                upd.data.count = ent.count - 32'd1;
                if (ent.fill != '0)
                begin
                    upd.data.selected = 1'b1;
                    rsp.woken_valid   = 1'b1;
                    rsp.woken_thread  = head_waiter;
                    rsp.status        = ST_REL_HANDOFF;
                end
                else
                    rsp.status = ST_REL_FREE;
            end
        end
    end

endmodule

// ===== rtl/core/recursive_lock_manager.sv =====
// ----------------------------------------------------------------------------
// recursive_lock_manager
// Recursive lock table with FIFO waiters, one command per cycle.
// ----------------------------------------------------------------------------
// The result strobe follows start through the input register, then the result
// register. Throughput: one command per cycle; busy is always low.
// The combinational tag match and entry update set that rate.
// Reset clears valid bits, stop state and strobes; no results are lost on a
// stall because the receiver cannot stall.
module recursive_lock_manager (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rlm_pkg::req_t  req,
    output logic           done,
    output rlm_pkg::rsp_t  rsp
);
    import rlm_pkg::*;

    req_t                req_reg;
    logic                go_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                done_reg;
    lookup_t             lkp;
    entry_t              ent;
    logic [31:0]         head_waiter;
    logic                stopping;
    logic [SLOT_W-1:0]   rd_slot;
    update_t             upd;

    assign busy = 1'b0;

    rlm_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (req_reg.lock_address[31:2]),
        .rd_slot     (rd_slot),
        .upd         (upd),
        .lkp         (lkp),
        .hit_entry   (ent),
        .head_waiter (head_waiter),
        .stopping    (stopping)
    );

    rlm_ctrl u_ctrl (
        .req         (req_reg),
        .go          (go_reg),
        .lkp         (lkp),
        .ent         (ent),
        .head_waiter (head_waiter),
        .stopping    (stopping),
        .rd_slot     (rd_slot),
        .upd         (upd),
        .rsp         (rsp_next)
    );

    // Advance strobes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            go_reg   <= start;
            done_reg <= go_reg;
        end
    end

    // Capture input and result
    always_ff @(posedge clk)
    begin
        if (start)
            req_reg <= req;
        if (go_reg)
            rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
